FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top level of the timer table
// no dependencies; each macro takes a label, clock, reset and message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// expression holds on every cycle out of reset
`define STT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

FILE: hw/rtl/stt_pkg.sv
// shared types and constants for the software timer table unit
// no dependencies; used by the controller, the datapath and the top level
package stt_pkg;

   localparam int NUM_SLOTS_DEF   = 10;
   localparam int CLIENT_BITS_DEF = 8;

   localparam int MODE_W      = 3;
   localparam int CLIENT_ID_W = 8;
   localparam int PERIOD_W    = 32;

   localparam logic [MODE_W-1:0] MODE_START_ONE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_START_PER = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RESTART   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TICK      = 3'd4;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_EXPIRE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch the request, clear scan flags
      logic prime;   // read slot zero
      logic step;    // process the slot in the read register
      logic finish;  // deliver the closing result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stall;      // expiry notice blocked by a full output register
      logic last_slot;  // read register holds the highest slot
      logic done;       // closing result delivered or none needed
   } status_type;

endpackage

FILE: hw/rtl/software_timer_table_unit.sv
// Software timer table: NUM_SLOTS countdown slots, each bound to a client id.
// Commands (start one-shot, start periodic, stop, restart) return one
// acknowledge; a tick returns one expiry notice per slot that reaches zero,
// lowest slot first, with last set on the final one, and nothing if no slot
// expires. Every request walks the slot memory one slot per cycle unless an
// expiry notice stalls the scan, and no new request is taken until it is done.
// Any request, a command as well as a tick, takes longer only while one of
// its results waits behind an unaccepted result at the output. The slot
// memory has per-slot valid bits cleared by reset, so there is no clearing
// pass. A result may wait at the output while the next request is taken.
`include "assert_macros.svh"

module software_timer_table_unit #(
   parameter int NUM_SLOTS   = stt_pkg::NUM_SLOTS_DEF,
   parameter int CLIENT_BITS = stt_pkg::CLIENT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [stt_pkg::MODE_W-1:0]      req_mode,
   input  logic [stt_pkg::CLIENT_ID_W-1:0] req_client_id,
   input  logic [stt_pkg::PERIOD_W-1:0]    req_period_ticks,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic                            rsp_ok,
   output logic [stt_pkg::CLIENT_ID_W-1:0] rsp_expired_client,
   output logic                            rsp_last
);
   import stt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stt_datapath #(
      .NUM_SLOTS   (NUM_SLOTS),
      .CLIENT_BITS (CLIENT_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_client_id      (req_client_id),
      .req_period_ticks   (req_period_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_ok             (rsp_ok),
      .rsp_expired_client (rsp_expired_client),
      .rsp_last           (rsp_last)
   );

   `STT_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0({cmd.load, cmd.prime, cmd.step, cmd.finish}), "more than one controller command at once")
   `STT_ASSERT_NEXT(a_load_prime, clock, reset, cmd.load, cmd.prime, "request taken without priming the slot read")
   `STT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "new request taken during a scan")
   `STT_ASSERT_NEXT(a_idle_after_done, clock, reset, cmd.finish && sts.done, req_ready, "block not ready after closing result")

endmodule

FILE: hw/rtl/stt_ctrl.sv
// sequencer for the timer table: load, prime, slot scan, finish
// depends on stt_pkg for the command and status structs
module stt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stt_pkg::status_type sts,
   output stt_pkg::cmd_type    cmd
);
   import stt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PRIME  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (!sts.stall && sts.last_slot) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/stt_datapath.sv
// slot memory, scan logic and output register of the timer table
// depends on stt_pkg; driven by stt_ctrl through command and status structs
module stt_datapath #(
   parameter int NUM_SLOTS   = stt_pkg::NUM_SLOTS_DEF,
   parameter int CLIENT_BITS = stt_pkg::CLIENT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stt_pkg::cmd_type                    cmd,
   output stt_pkg::status_type                 sts,
   input  logic [stt_pkg::MODE_W-1:0]          req_mode,
   input  logic [stt_pkg::CLIENT_ID_W-1:0]     req_client_id,
   input  logic [stt_pkg::PERIOD_W-1:0]        req_period_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic                                rsp_ok,
   output logic [stt_pkg::CLIENT_ID_W-1:0]     rsp_expired_client,
   output logic                                rsp_last
);
   import stt_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   typedef struct packed {
      logic                   periodic;
      logic [CLIENT_BITS-1:0] client;
      logic [PERIOD_W-1:0]    period;
      logic [PERIOD_W-1:0]    count;
   } slot_type;

   slot_type slot_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_vld_ff;

   logic [MODE_W-1:0]      mode_ff;
   logic [CLIENT_BITS-1:0] client_ff;
   logic [PERIOD_W-1:0]    period_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   found_ff, found_in;
   logic                   pend_ff, pend_in;
   logic [CLIENT_BITS-1:0] pend_client_ff, pend_client_in;
   slot_type               rd_ff;
   logic                   rd_vld_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_ok_ff, rsp_last_ff;
   logic [CLIENT_ID_W-1:0] rsp_client_ff;

   slot_type         eff, wr_word;
   logic             is_tick, client_ok, cnt_nz, cnt_one, expire;
   logic             out_free, stall, hit, we, advance, re, push, push_mid, done;
   logic [IDX_W-1:0] rd_addr;
   logic             push_kind, push_ok, push_last;
   logic [CLIENT_ID_W-1:0] push_client;

   // a slot never written reads as all zero
   assign eff       = rd_vld_ff ? rd_ff : '0;
   assign is_tick   = (mode_ff == MODE_TICK);
   assign client_ok = (client_ff != '0);
   assign cnt_nz    = (eff.count != '0);
   assign cnt_one   = (eff.count == PERIOD_W'(1));
   assign expire    = is_tick && cnt_one;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a second notice cannot advance until the held one has somewhere to go
   assign stall     = cmd.step && expire && pend_ff && !out_free;

   always_comb begin
      hit     = 1'b0;
      wr_word = eff;
      case (mode_ff) inside
         MODE_START_ONE, MODE_START_PER: begin
            hit     = client_ok && !found_ff && (eff.client == '0);
            wr_word = '{periodic: (mode_ff == MODE_START_PER), client: client_ff,
                        period: period_ff, count: period_ff};
         end
         MODE_STOP: begin
            hit           = client_ok && !found_ff && (eff.client == client_ff);
            wr_word.count = '0;
         end
         MODE_RESTART: begin
            hit           = client_ok && !found_ff && (eff.client == client_ff);
            wr_word.count = eff.period;
         end
         MODE_TICK: begin
            if (cnt_one) begin
               wr_word.count = eff.periodic ? eff.period : '0;
            end else begin
               wr_word.count = eff.count - PERIOD_W'(1);
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   assign we      = cmd.step && !stall && (is_tick ? cnt_nz : hit);
   assign advance = cmd.step && !stall && (idx_ff != LAST_IDX);
   assign re      = cmd.prime || advance;
   assign rd_addr = cmd.prime ? '0 : idx_ff + IDX_W'(1);

   always_comb begin
      idx_in         = idx_ff;
      found_in       = found_ff;
      pend_in        = pend_ff;
      pend_client_in = pend_client_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         pend_in  = 1'b0;
      end
      if (re) begin
         idx_in = rd_addr;
      end
      if (cmd.step && !stall && hit) begin
         found_in = 1'b1;
      end
      // hold each notice until the next one or the end of the scan sets its last flag
      if (cmd.step && !stall && expire) begin
         pend_in        = 1'b1;
         pend_client_in = eff.client;
      end
   end

   assign push_mid = cmd.step && expire && pend_ff && out_free;
   assign push     = push_mid || (cmd.finish && out_free && (!is_tick || pend_ff));
   assign done     = cmd.finish && (out_free || (is_tick && !pend_ff));

   always_comb begin
      if (is_tick) begin
         push_kind   = KIND_EXPIRE;
         push_ok     = 1'b1;
         push_client = CLIENT_ID_W'(pend_client_ff);
         push_last   = cmd.finish;
      end else begin
         push_kind   = KIND_ACK;
         push_ok     = found_ff;
         push_client = '0;
         push_last   = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[idx_ff] <= wr_word;
      end
      if (re) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (we) begin
            slot_vld_ff[idx_ff] <= 1'b1;
         end
         if (re) begin
            rd_vld_ff <= slot_vld_ff[rd_addr];
         end
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         client_ff <= CLIENT_BITS'(req_client_id);
         period_ff <= req_period_ticks;
      end
      pend_client_ff <= pend_client_in;
      if (push) begin
         rsp_kind_ff   <= push_kind;
         rsp_ok_ff     <= push_ok;
         rsp_client_ff <= push_client;
         rsp_last_ff   <= push_last;
      end
   end

   assign sts.stall     = stall;
   assign sts.last_slot = (idx_ff == LAST_IDX);
   assign sts.done      = done;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_expired_client = rsp_client_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

FILE: tb/tb_software_timer_table_unit.sv
// self-checking testbench for software_timer_table_unit: directed and random requests
// against a behavioral model of the timer table; depends only on stt_pkg and the dut
module tb_software_timer_table_unit;
   import stt_pkg::*;

   localparam int CLIENT_BITS = CLIENT_BITS_DEF;
   localparam int SLOT_COUNT  = NUM_SLOTS_DEF;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_TICK + 1'b1;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

   typedef struct packed {
      logic                   kind;
      logic                   ok;
      logic [CLIENT_ID_W-1:0] client;
      logic                   last;
   } timer_result_type;

   typedef struct {
      logic [MODE_W-1:0]      mode;
      logic [CLIENT_ID_W-1:0] client;
      logic [PERIOD_W-1:0]    period;
      bit                     drain_first;
   } timer_req_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SLOW} rx_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [MODE_W-1:0] req_mode = '0;
   logic [CLIENT_ID_W-1:0] req_client_id = '0;
   logic [PERIOD_W-1:0] req_period_ticks = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic rsp_ok;
   logic [CLIENT_ID_W-1:0] rsp_expired_client;
   logic rsp_last;

   // model of the slot table
   logic [CLIENT_BITS-1:0] tbl_client [SLOT_COUNT];
   logic [PERIOD_W-1:0]    tbl_period [SLOT_COUNT];
   logic [PERIOD_W-1:0]    tbl_count  [SLOT_COUNT];
   logic                   tbl_periodic [SLOT_COUNT];

   timer_req_type    pending_reqs [$];
   timer_result_type due_results [$];

   int presented_count = 0;
   int accepted_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int fail_count = 0;
   int ack_count = 0;
   int refused_count = 0;
   int notice_count = 0;
   int tick_count = 0;
   int peak_notices = 0;
   int rx_phase = 0;
   int rx_cycle = 0;
   rx_style_type rx_style = RX_OPEN;
   timer_req_type next_req;
   timer_result_type got;
   timer_result_type want;
   logic next_valid;

   software_timer_table_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_client_id(req_client_id),
      .req_period_ticks(req_period_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_ok(rsp_ok),
      .rsp_expired_client(rsp_expired_client),
      .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   // applies one request to the model and queues the results it should produce
   function automatic void advance_timer_table(input logic [MODE_W-1:0] mode,
                                               input logic [CLIENT_ID_W-1:0] cid,
                                               input logic [PERIOD_W-1:0] period);
      logic [CLIENT_BITS-1:0] id;
      logic [CLIENT_BITS-1:0] fired [$];
      logic ok;
      int hit;
      id = cid[CLIENT_BITS-1:0];
      ok = 1'b0;
      hit = -1;
      if (mode == MODE_TICK) begin
         tick_count++;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_count[i] != '0) begin
               tbl_count[i] = tbl_count[i] - 1'b1;
               if (tbl_count[i] == '0) begin
                  if (tbl_periodic[i]) tbl_count[i] = tbl_period[i];
                  fired.push_back(tbl_client[i]);
               end
            end
         end
         foreach (fired[j])
            due_results.push_back('{KIND_EXPIRE, 1'b1, CLIENT_ID_W'(fired[j]),
                                    j == fired.size() - 1});
         if (fired.size() > peak_notices) peak_notices = fired.size();
      end else begin
         if (id != '0) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (hit < 0) begin
                  if ((mode == MODE_START_ONE || mode == MODE_START_PER) && tbl_client[i] == '0)
                     hit = i;
                  if ((mode == MODE_STOP || mode == MODE_RESTART) && tbl_client[i] == id)
                     hit = i;
               end
            end
         end
         if (hit >= 0) begin
            ok = 1'b1;
            case (mode)
               MODE_START_ONE, MODE_START_PER: begin
                  tbl_client[hit] = id;
                  tbl_period[hit] = period;
                  tbl_count[hit] = period;
                  tbl_periodic[hit] = (mode == MODE_START_PER);
               end
               MODE_STOP: begin
                  tbl_count[hit] = '0;
               end
               MODE_RESTART: begin
                  tbl_count[hit] = tbl_period[hit];
               end
               default: begin
                  ok = 1'b0;
               end
            endcase
         end
         due_results.push_back('{KIND_ACK, ok, '0, 1'b1});
      end
   endfunction

   task automatic add_req(input logic [MODE_W-1:0] mode, input logic [CLIENT_ID_W-1:0] cid,
                          input logic [PERIOD_W-1:0] period, input bit drain_first = 0);
      pending_reqs.push_back('{mode, cid, period, drain_first});
   endtask

   // response checker and request capture, both on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_ok, rsp_expired_client, rsp_last};
            if (due_results.size() == 0) begin
               $error("unexpected response: kind %0d ok %0d client %0d last %0d",
                      got.kind, got.ok, got.client, got.last);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got.kind != want.kind) begin
                  $error("rsp_kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.ok != want.ok) begin
                  $error("rsp_ok: expected %0d, got %0d", want.ok, got.ok);
                  fail_count++;
               end
               if (got.client != want.client) begin
                  $error("rsp_expired_client: expected %0d, got %0d", want.client, got.client);
                  fail_count++;
               end
               if (got.last != want.last) begin
                  $error("rsp_last: expected %0d, got %0d", want.last, got.last);
                  fail_count++;
               end
               if (want.kind == KIND_EXPIRE) notice_count++;
               else begin
                  ack_count++;
                  if (!want.ok) refused_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_timer_table(req_mode, req_client_id, req_period_ticks);
            accepted_count++;
         end
      end
   end

   // request driver: bursts of back-to-back requests separated by random gaps
   always @(negedge clock) begin
      if (!reset && presented_count == accepted_count) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first && due_results.size() != 0)) begin
            next_req = pending_reqs.pop_front();
            next_valid = 1'b1;
            presented_count++;
            req_mode <= next_req.mode;
            req_client_id <= next_req.client;
            req_period_ticks <= next_req.period;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left--;
            end
         end
         req_valid <= next_valid;
      end
   end

   // response side: open, random or slow stretches
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_phase == 0) begin
         rx_style = rx_style_type'($urandom_range(0, 2));
         rx_phase = $urandom_range(16, 80);
      end else begin
         rx_phase--;
      end
      case (rx_style)
         RX_OPEN: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 9) < 6);
         default: rsp_ready <= (rx_cycle % 8 == 0);
      endcase
   end

   initial begin
      logic [CLIENT_ID_W-1:0] known [10];
      int pick;
      logic [CLIENT_ID_W-1:0] cid;
      logic [PERIOD_W-1:0] period;
      known = '{8'd255, 8'd1, 8'd2, 8'd3, 8'd1, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
      for (int i = 0; i < SLOT_COUNT; i++) begin
         tbl_client[i] = '0;
         tbl_period[i] = '0;
         tbl_count[i] = '0;
         tbl_periodic[i] = 1'b0;
      end

      // directed part
      add_req(MODE_TICK, 8'd9, 32'd0);             // quiet tick on an empty table
      add_req(MODE_START_ONE, 8'd0, 32'd5);        // client zero is refused
      add_req(MODE_START_ONE, 8'd255, 32'd1);
      add_req(MODE_START_PER, 8'd1, 32'd2);
      add_req(MODE_START_ONE, 8'd2, 32'd0);        // zero period never expires
      add_req(MODE_START_PER, 8'd3, 32'hFFFF_FFFF);
      add_req(MODE_TICK, 8'd0, 32'd0);
      add_req(MODE_TICK, 8'd0, 32'd0);
      add_req(MODE_STOP, 8'd77, 32'd0);            // no such client
      add_req(MODE_RESTART, 8'd0, 32'd0);
      add_req(MODE_STOP, 8'd1, 32'd0);
      add_req(MODE_RESTART, 8'd2, 32'd0);
      add_req(MODE_SPARE_LO, 8'd1, 32'hFFFF_FFFF);
      add_req(MODE_SPARE_HI - 1'b1, 8'd3, 32'd1);
      add_req(MODE_SPARE_HI, 8'd255, 32'd2);
      add_req(MODE_START_PER, 8'd1, 32'd3);        // duplicate client, lower slot wins
      add_req(MODE_START_PER, 8'h80, 32'd1);
      add_req(MODE_START_PER, 8'h55, 32'd4);
      add_req(MODE_START_ONE, 8'hAA, 32'd5);
      add_req(MODE_START_PER, 8'h0F, 32'd2);
      add_req(MODE_START_PER, 8'hF0, 32'd1);
      add_req(MODE_START_ONE, 8'h33, 32'd7);       // table is full now
      add_req(MODE_RESTART, 8'd1, 32'd0);
      add_req(MODE_RESTART, 8'd255, 32'd0);
      add_req(MODE_TICK, 8'd0, 32'd0, 1);          // hold until everything drained

      // random part, mostly ticks and commands aimed at clients in the table
      for (int n = 0; n < 190; n++) begin
         pick = $urandom_range(0, 99);
         cid = ($urandom_range(0, 9) < 8) ? known[$urandom_range(0, 9)] : CLIENT_ID_W'($urandom);
         period = ($urandom_range(0, 1) == 0) ? PERIOD_W'($urandom_range(0, 6)) : $urandom;
         if (pick < 45) add_req(MODE_TICK, CLIENT_ID_W'($urandom), $urandom, n % 70 == 69);
         else if (pick < 60) add_req(MODE_STOP, cid, period);
         else if (pick < 80) add_req(MODE_RESTART, cid, period);
         else if (pick < 86) add_req(MODE_START_ONE, cid, period);
         else if (pick < 92) add_req(MODE_START_PER, cid, period);
         else add_req(MODE_TICK + MODE_W'($urandom_range(1, 3)), cid, period);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || presented_count != accepted_count) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d requests (%0d ticks): %0d acknowledges, %0d of them refused,",
               accepted_count, tick_count, ack_count, refused_count);
      $display("and %0d expiry notices, up to %0d from a single tick", notice_count, peak_notices);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $error("timeout with %0d results outstanding", due_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
